FILE: hw/rtl/fqa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes and the sideband record that travels down the pipeline.
// ----------------------------------------------------------------------------
package fqa_pkg;

  localparam int DefaultFractionBits = 8;
  localparam int DataWidth = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_GT       = 4'd5,
    OP_LE       = 4'd6,
    OP_GE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef struct packed {
    logic                 valid;
    logic                 is_div;
    logic                 neg;
    logic                 cmp;
    logic                 dz;
    logic [DataWidth-1:0] res;
  } side_t;

endpackage

FILE: hw/rtl/fqa_front.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Registers the operands and product, then forms simple results and the
// divider start state.
// ----------------------------------------------------------------------------
module fqa_front #(
  parameter int FRACTION_BITS = fqa_pkg::DefaultFractionBits
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  fqa_pkg::op_t                      in_op,
  input  logic signed [31:0]                in_a,
  input  logic signed [31:0]                in_b,
  output fqa_pkg::side_t                    side,
  output logic [31:0]                       rem,
  output logic [32+FRACTION_BITS-1:0]       qd,
  output logic [31:0]                       dv
);
  import fqa_pkg::*;

  logic               a_valid;
  op_t                a_op;
  logic signed [31:0] a_a;
  logic signed [31:0] a_b;
  logic signed [63:0] a_prod;

  logic signed [63:0] prod_sh;
  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  side_t              side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op   <= in_op;
      a_a    <= in_a;
      a_b    <= in_b;
      a_prod <= 64'(in_a) * 64'(in_b);
    end
  end

  always_comb begin
    prod_sh = a_prod >>> FRACTION_BITS;
    mag_a = a_a[31] ? 32'(-a_a) : a_a;
    mag_b = a_b[31] ? 32'(-a_b) : a_b;
    side_next = '0;
    side_next.valid = a_valid;
    unique case (a_op)
      OP_ADD:      side_next.res = a_a + a_b;
      OP_SUB:      side_next.res = a_a - a_b;
      OP_MUL:      side_next.res = prod_sh[31:0];
      OP_DIV: begin
        side_next.is_div = 1'b1;
        side_next.dz     = (a_b == 32'sd0);
        side_next.neg    = a_a[31] ^ a_b[31];
      end
      OP_LT:       side_next.cmp = (a_a < a_b);
      OP_GT:       side_next.cmp = (a_a > a_b);
      OP_LE:       side_next.cmp = (a_a <= a_b);
      OP_GE:       side_next.cmp = (a_a >= a_b);
      OP_EQ:       side_next.cmp = (a_a == a_b);
      OP_NE:       side_next.cmp = (a_a != a_b);
      OP_MIN:      side_next.res = (a_a < a_b) ? a_a : a_b;
      OP_MAX:      side_next.res = (a_a > a_b) ? a_a : a_b;
      OP_INC:      side_next.res = a_a + 32'sd1;
      OP_DEC:      side_next.res = a_a - 32'sd1;
      OP_FROM_INT: side_next.res = a_a << FRACTION_BITS;
      OP_TO_INT:   side_next.res = a_a >>> FRACTION_BITS;
      default:     side_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side <= side_next;
      rem  <= '0;
      qd   <= {mag_a, {FRACTION_BITS{1'b0}}};
      dv   <= mag_b;
    end
  end

endmodule

FILE: hw/rtl/fqa_div_stage.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU divider stage
// One restoring division step: produces one quotient bit per stage.
// ----------------------------------------------------------------------------
module fqa_div_stage #(
  parameter int FRACTION_BITS = fqa_pkg::DefaultFractionBits
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  fqa_pkg::side_t              in_side,
  input  logic [31:0]                 in_rem,
  input  logic [32+FRACTION_BITS-1:0] in_qd,
  input  logic [31:0]                 in_dv,
  output fqa_pkg::side_t              side,
  output logic [31:0]                 rem,
  output logic [32+FRACTION_BITS-1:0] qd,
  output logic [31:0]                 dv
);
  import fqa_pkg::*;

  localparam int W = 32 + FRACTION_BITS;

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    shifted = {in_rem, in_qd[W-1]};
    diff    = shifted - {1'b0, in_dv};
    ge      = (shifted >= {1'b0, in_dv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side <= in_side;
      rem  <= ge ? diff[31:0] : shifted[31:0];
      qd   <= {in_qd[W-2:0], ge};
      dv   <= in_dv;
    end
  end

endmodule

FILE: hw/rtl/fqa_back.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Applies the quotient sign and registers the result word.
// ----------------------------------------------------------------------------
module fqa_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  fqa_pkg::side_t in_side,
  input  logic [31:0]    in_q,
  output logic           out_valid,
  output logic [31:0]    out_res,
  output logic           out_cmp,
  output logic           out_dz
);
  import fqa_pkg::*;

  logic [31:0] res_next;

  always_comb begin
    if (in_side.is_div) begin
      if (in_side.dz) begin
        res_next = '0;
      end else begin
        res_next = in_side.neg ? 32'(-in_q) : in_q;
      end
    end else begin
      res_next = in_side.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res_next;
      out_cmp <= in_side.cmp;
      out_dz  <= in_side.dz;
    end
  end

endmodule

FILE: hw/rtl/fixed_point_q24_8_alu_top.sv
// ----------------------------------------------------------------------------
// Takes one word per cycle whenever no output word is waiting to be taken.
// Depth is set by the divider: one restoring stage per quotient bit.
// The whole pipeline holds while the output word waits to be taken.
// Synchronous active-high reset clears all valid bits; no kept state.
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU top level
// Signed fixed-point add, sub, mul, div, compare, min/max, inc/dec, convert.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top #(
  parameter int FRACTION_BITS = fqa_pkg::DefaultFractionBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_tuser,   // action [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value [31:0]
  output logic [1:0]  m_tuser    // compare_true [0], divide_by_zero [1]
);
  import fqa_pkg::*;

  localparam int W = 32 + FRACTION_BITS;

  logic  en;
  side_t side_q [W+1];
  logic [31:0]  rem_q [W+1];
  logic [W-1:0] qd_q  [W+1];
  logic [31:0]  dv_q  [W+1];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  fqa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_op    (op_t'(s_tuser)),
    .in_a     (s_tdata[31:0]),
    .in_b     (s_tdata[63:32]),
    .side     (side_q[0]),
    .rem      (rem_q[0]),
    .qd       (qd_q[0]),
    .dv       (dv_q[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_div
    fqa_div_stage #(.FRACTION_BITS(FRACTION_BITS)) u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_side (side_q[i]),
      .in_rem  (rem_q[i]),
      .in_qd   (qd_q[i]),
      .in_dv   (dv_q[i]),
      .side    (side_q[i+1]),
      .rem     (rem_q[i+1]),
      .qd      (qd_q[i+1]),
      .dv      (dv_q[i+1])
    );
  end

  fqa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_side   (side_q[W]),
    .in_q      (qd_q[W][31:0]),
    .out_valid (m_tvalid),
    .out_res   (m_tdata),
    .out_cmp   (m_tuser[0]),
    .out_dz    (m_tuser[1])
  );

endmodule

FILE: sim/fixed_point_q24_8_alu_checker.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU result checker
// Watches both stream channels, computes the expected result of every
// accepted word and compares each output word against the oldest one.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_checker #(
  parameter int FRACTION_BITS = fqa_pkg::DefaultFractionBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          error_count,
  output int          pending_count
);
  import fqa_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        is_true;
    logic        div_zero;
  } alu_result_t;

  alu_result_t results_due[$];

  function automatic alu_result_t compute_alu(op_t op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] wide;
    logic signed [63:0] num;
    r = '0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        wide = 64'(a) * 64'(b);
        wide = wide >>> FRACTION_BITS;
        r.value = wide[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.div_zero = 1'b1;
        end else begin
          num = 64'(a) <<< FRACTION_BITS;
          wide = num / 64'(b);
          r.value = wide[31:0];
        end
      end
      OP_LT: r.is_true = a < b;
      OP_GT: r.is_true = a > b;
      OP_LE: r.is_true = a <= b;
      OP_GE: r.is_true = a >= b;
      OP_EQ: r.is_true = a == b;
      OP_NE: r.is_true = a != b;
      OP_MIN: r.value = (a < b) ? a : b;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_INC: r.value = a + 1;
      OP_DEC: r.value = a - 1;
      OP_FROM_INT: r.value = a << FRACTION_BITS;
      default: r.value = a >>> FRACTION_BITS;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t want;
    alu_result_t got;
    if (rst) begin
      error_count <= 0;
      pending_count <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        results_due.push_back(compute_alu(op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]));
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tuser[0], m_tuser[1]};
        if (results_due.size() == 0) begin
          if (error_count < 10) begin
            $display("unexpected output word %h", got);
          end
          error_count <= error_count + 1;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            if (error_count < 10) begin
              $display("mismatch: expected value %h cmp %b dz %b, got value %h cmp %b dz %b",
                       want.value, want.is_true, want.div_zero,
                       got.value, got.is_true, got.div_zero);
            end
            error_count <= error_count + 1;
          end
        end
      end
      pending_count <= results_due.size();
    end
  end
endmodule

FILE: sim/fixed_point_q24_8_alu_top_test.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed corner words and about 1150 random words with random gaps
// on both sides, including one long output stall, and reports the verdict.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top_test;
  import fqa_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  int          error_count;
  int          pending_count;
  int          cycle_count = 0;
  bit          stimulus_done = 1'b0;

  always #2 clk = ~clk;

  fixed_point_q24_8_alu_top dut (.*);
  fixed_point_q24_8_alu_checker checker_i (.*);

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h1;
      4: return 32'($signed($urandom_range(0, 2047)) - 1024);
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  task automatic send_word(op_t op, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = pick_gap();
    if ($urandom_range(0, 2) == 0 && gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 300; k++) begin
      m_tready <= ($urandom_range(0, 3) != 0);
      @(posedge clk);
    end
    m_tready <= 1'b0;
    repeat (150) @(posedge clk);
    while (!stimulus_done) begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        n = pick_gap() + 1;
        repeat (n) @(posedge clk);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
    m_tready <= 1'b1;
  end

  initial begin
    op_t ops[16];
    @(negedge rst);
    @(posedge clk);
    for (int k = 0; k < 16; k++) ops[k] = op_t'(k);
    foreach (ops[k]) send_word(ops[k], 32'h8000_0000, 32'h7fff_ffff);
    send_word(OP_DIV, 32'h0000_0100, 32'h0);
    send_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_MIN, 32'h0000_1234, 32'h0000_1234);
    send_word(OP_MAX, 32'hffff_fe00, 32'hffff_fe00);
    send_word(OP_TO_INT, 32'hffff_ff01, 32'h0);
    send_word(OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
    send_word(OP_EQ, 32'hffff_ffff, 32'hffff_ffff);
    for (int k = 0; k < 1150; k++) begin
      logic [31:0] a;
      a = pick_operand();
      send_word(op_t'($urandom_range(0, 15)), a,
                ($urandom_range(0, 7) == 0) ? a : pick_operand());
    end
    s_tvalid <= 1'b0;
    stimulus_done = 1'b1;
    @(posedge clk);
    while (pending_count != 0 || m_tvalid) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
